[rtl/core/force_vector_rotate_core_macros.svh]
// Assertion macros for the force vector rotation core.
// Both expect clk and rst in scope and are disabled while rst is high.
`ifndef FORCE_VECTOR_ROTATE_CORE_MACROS_SVH
`define FORCE_VECTOR_ROTATE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge.
`define FVR_CHECK(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("fvr: invariant violated");

// Check that a consequence follows a trigger after the delay given in n.
`define FVR_CHECK_AFTER(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("fvr: delayed check violated");

`else

`define FVR_CHECK(label, expr)
`define FVR_CHECK_AFTER(label, ante, n, cons)

`endif

`endif

[rtl/core/fvr_pkg.sv]
package fvr_pkg;

  localparam int DEF_CORDIC_STEPS    = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 6;

  // Angles run in 2^-24 degree, vectors are the samples scaled by 2^12.
  localparam int FINE_BITS  = 24;
  localparam int VEC_SHIFT  = 12;
  localparam int VEC_W      = 31;
  localparam int ACC_W      = 35;
  localparam int TBL_LEN    = 24;

  // 1/K in Q30, product scaled back by 2^(30+12)
  localparam int GAIN_Q30   = 652032874;
  localparam int GAIN_SHIFT = 42;

  localparam logic signed [ACC_W-1:0] TURN_FINE      = ACC_W'(64'd360 << FINE_BITS);
  localparam logic signed [ACC_W-1:0] HALF_TURN_FINE = ACC_W'(64'd180 << FINE_BITS);

  // One item in flight through the rotator: vectoring lane (va, vb, vacc)
  // and rotation lane (ra, rb, rm), plus the reduced mount angle.
  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic signed [VEC_W-1:0] va;
    logic signed [VEC_W-1:0] vb;
    logic signed [ACC_W-1:0] vacc;
    logic signed [VEC_W-1:0] ra;
    logic signed [VEC_W-1:0] rb;
    logic signed [ACC_W-1:0] rm;
    logic signed [ACC_W-1:0] mf;
  } fvr_lane_t;

  // atan(2^-step) in 2^-24 degree, rounded to nearest
  function automatic logic signed [ACC_W-1:0] atan_fine(input int step);
    logic signed [ACC_W-1:0] r;
    case (step)
      0:       r = ACC_W'(754974720);
      1:       r = ACC_W'(445687602);
      2:       r = ACC_W'(235489088);
      3:       r = ACC_W'(119537938);
      4:       r = ACC_W'(60000934);
      5:       r = ACC_W'(30029717);
      6:       r = ACC_W'(15018523);
      7:       r = ACC_W'(7509720);
      8:       r = ACC_W'(3754917);
      9:       r = ACC_W'(1877466);
      10:      r = ACC_W'(938734);
      11:      r = ACC_W'(469367);
      12:      r = ACC_W'(234684);
      13:      r = ACC_W'(117342);
      14:      r = ACC_W'(58671);
      15:      r = ACC_W'(29335);
      16:      r = ACC_W'(14668);
      17:      r = ACC_W'(7334);
      18:      r = ACC_W'(3667);
      19:      r = ACC_W'(1833);
      20:      r = ACC_W'(917);
      21:      r = ACC_W'(458);
      22:      r = ACC_W'(229);
      23:      r = ACC_W'(115);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/force_vector_rotate_core.sv]
// Rotates a two-axis force sample (x_force, z_force) into the horizontal and
// vertical frame by the sensor mounting angle held in mount_angle (written
// through the cfg_valid/cfg_ready/cfg_data channel, 1/2^ANGLE_FRAC_BITS degree,
// any 16-bit value, reduced modulo 360). A sample is taken on every rising
// edge with start high and busy low, one per cycle with no gaps; busy is high
// only during reset. Each result appears on horiz_force, vert_force, force_angle
// and clipped, with done high for exactly one cycle. There is no output
// back-pressure: the receiver must take every result in the cycle it is shown.
// The pipeline is three front stages (mount reduction and lane set-up), one
// CORDIC step per stage for the vectoring and rotation lanes side by side, and
// two finishing stages (gain multiply, then truncation, saturation and angle
// rounding).
// Write the mount angle only while no sample is in flight; the new value
// applies from the next sample on.
`include "force_vector_rotate_core_macros.svh"

module force_vector_rotate_core
  import fvr_pkg::*;
#(
  parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] x_force,
  input  logic signed [15:0] z_force,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_data,
  output logic               done,
  output logic signed [15:0] horiz_force,
  output logic signed [15:0] vert_force,
  output logic [14:0]        force_angle,
  output logic               clipped
);

  localparam int LAT = CORDIC_STEPS + 5;

  logic in_beat;
  logic cfg_beat;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign in_beat   = start && !busy;
  assign cfg_beat  = cfg_valid && cfg_ready;

  fvr_lane_t lane [CORDIC_STEPS+1];

  fvr_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_beat  (in_beat),
    .x_force  (x_force),
    .z_force  (z_force),
    .cfg_beat (cfg_beat),
    .cfg_data (cfg_data),
    .q        (lane[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    fvr_step #(
      .STEP(g)
    ) u_step (
      .clk (clk),
      .rst (rst),
      .d   (lane[g]),
      .q   (lane[g+1])
    );
  end

  fvr_finish #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_finish (
    .clk         (clk),
    .rst         (rst),
    .d           (lane[CORDIC_STEPS]),
    .done        (done),
    .horiz_force (horiz_force),
    .vert_force  (vert_force),
    .force_angle (force_angle),
    .clipped     (clipped)
  );

  `FVR_CHECK_AFTER(result_follows_beat, in_beat, LAT, done)
  `FVR_CHECK(no_orphan_result, !done || $past(in_beat, LAT))
  `FVR_CHECK_AFTER(zero_sample_zero_result, in_beat && x_force == 16'sd0 && z_force == 16'sd0, LAT, horiz_force == 16'sd0 && vert_force == 16'sd0 && force_angle == 15'd0 && !clipped)
  `FVR_CHECK(clip_sits_on_rail, !(done && clipped) || horiz_force == 16'sh7fff || horiz_force == 16'sh8000 || vert_force == 16'sh7fff || vert_force == 16'sh8000)

endmodule

[rtl/core/fvr_front.sv]
module fvr_front
  import fvr_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_beat,
  input  logic signed [15:0] x_force,
  input  logic signed [15:0] z_force,
  input  logic               cfg_beat,
  input  logic signed [15:0] cfg_data,
  output fvr_lane_t          q
);

  localparam int TURN    = 360 << ANGLE_FRAC_BITS;
  localparam int HALF    = 180 << ANGLE_FRAC_BITS;
  localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
  localparam int WRAPS   = (32768 + TURN - 1) / TURN;
  localparam int OFFSET  = WRAPS * TURN;
  localparam int U_W     = $clog2(OFFSET + 32768);
  localparam longint RECIP = (longint'(1) << 32) / TURN;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int P_W     = U_W + RECIP_W;
  localparam int Q_W     = $clog2(2 * WRAPS + 1);
  localparam int MR_W    = $clog2(TURN);
  localparam int SW      = MR_W + 2;
  localparam int SH      = FINE_BITS - ANGLE_FRAC_BITS;

  localparam logic [U_W-1:0]       TURN_U     = U_W'(TURN);
  localparam logic signed [SW-1:0] TURN_S     = SW'(TURN);
  localparam logic signed [SW-1:0] HALF_S     = SW'(HALF);
  localparam logic signed [SW-1:0] QUARTER_S  = SW'(QUARTER);
  localparam logic signed [SW-1:0] NQUARTER_S = SW'(-QUARTER);

  logic signed [15:0] mount;

  always_ff @(posedge clk) begin
    if (rst) begin
      mount <= '0;
    end else if (cfg_beat) begin
      mount <= cfg_data;
    end
  end

  // Stage 0: shift the mount angle positive and estimate its turn count
  logic signed [U_W:0] u_wide;
  logic [U_W-1:0]      u;
  logic [P_W-1:0]      prod;
  logic [Q_W-1:0]      qest;

  assign u_wide = (U_W+1)'(mount) + (U_W+1)'(OFFSET);
  assign u      = u_wide[U_W-1:0];
  assign prod   = P_W'(u) * P_W'(RECIP);
  assign qest   = Q_W'(prod >> 32);

  logic               s0_valid;
  logic               s0_zero;
  logic signed [15:0] s0_x;
  logic signed [15:0] s0_z;
  logic [U_W-1:0]     s0_u;
  logic [Q_W-1:0]     s0_q;

  // Stage 1: remainder, the estimate may be one short
  logic [U_W-1:0] qm;
  logic [U_W-1:0] r;
  logic [U_W-1:0] r_fix;

  assign qm    = U_W'(s0_q) * TURN_U;
  assign r     = s0_u - qm;
  assign r_fix = (r >= TURN_U) ? r - TURN_U : r;

  logic               s1_valid;
  logic               s1_zero;
  logic signed [15:0] s1_x;
  logic signed [15:0] s1_z;
  logic [MR_W-1:0]    s1_mr;

  // Stage 2: fold the rotation into [-90, 90] and set up both lanes
  logic signed [SW-1:0]    ms_raw;
  logic signed [SW-1:0]    ms;
  logic signed [SW-1:0]    rm0;
  logic                    fold;
  logic signed [VEC_W-1:0] zs;
  logic signed [VEC_W-1:0] xs;
  fvr_lane_t               stage2_next;
  fvr_lane_t               stage2;

  assign zs = VEC_W'(s1_z) <<< VEC_SHIFT;
  assign xs = VEC_W'(s1_x) <<< VEC_SHIFT;

  always_comb begin
    ms_raw = $signed({2'b00, s1_mr});
    ms     = (ms_raw > HALF_S) ? ms_raw - TURN_S : ms_raw;
    fold   = 1'b0;
    rm0    = ms;
    if (ms > QUARTER_S) begin
      fold = 1'b1;
      rm0  = ms - HALF_S;
    end else if (ms < NQUARTER_S) begin
      fold = 1'b1;
      rm0  = ms + HALF_S;
    end

    stage2_next.valid = s1_valid;
    stage2_next.zero  = s1_zero;
    // vectoring works in the right half plane: flip and start from 180
    stage2_next.va    = s1_z[15] ? -zs : zs;
    stage2_next.vb    = s1_z[15] ? -xs : xs;
    stage2_next.vacc  = s1_z[15] ? HALF_TURN_FINE : '0;
    stage2_next.ra    = fold ? -zs : zs;
    stage2_next.rb    = fold ? -xs : xs;
    stage2_next.rm    = ACC_W'(rm0) <<< SH;
    stage2_next.mf    = ACC_W'({1'b0, s1_mr}) << SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid     <= 1'b0;
      s1_valid     <= 1'b0;
      stage2.valid <= 1'b0;
    end else begin
      s0_valid <= in_beat;
      s1_valid <= s0_valid;
      stage2   <= stage2_next;
    end
  end

  always_ff @(posedge clk) begin
    s0_zero <= (x_force == 16'sd0) && (z_force == 16'sd0);
    s0_x    <= x_force;
    s0_z    <= z_force;
    s0_u    <= u;
    s0_q    <= qest;
    s1_zero <= s0_zero;
    s1_x    <= s0_x;
    s1_z    <= s0_z;
    s1_mr   <= r_fix[MR_W-1:0];
  end

  assign q = stage2;

endmodule

[rtl/core/fvr_step.sv]
module fvr_step
  import fvr_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  fvr_lane_t d,
  output fvr_lane_t q
);

  localparam logic signed [ACC_W-1:0] ATAN = atan_fine(STEP);

  logic signed [VEC_W-1:0] va;
  logic signed [VEC_W-1:0] vb;
  logic signed [VEC_W-1:0] ra;
  logic signed [VEC_W-1:0] rb;
  logic signed [VEC_W-1:0] va_sh;
  logic signed [VEC_W-1:0] vb_sh;
  logic signed [VEC_W-1:0] ra_sh;
  logic signed [VEC_W-1:0] rb_sh;
  fvr_lane_t               n;

  assign va    = d.va;
  assign vb    = d.vb;
  assign ra    = d.ra;
  assign rb    = d.rb;
  assign va_sh = va >>> STEP;
  assign vb_sh = vb >>> STEP;
  assign ra_sh = ra >>> STEP;
  assign rb_sh = rb >>> STEP;

  always_comb begin
    n = d;
    // vectoring: drive vb towards zero
    if (!vb[VEC_W-1] && (vb != '0)) begin
      n.va   = va + vb_sh;
      n.vb   = vb - va_sh;
      n.vacc = d.vacc + ATAN;
    end else begin
      n.va   = va - vb_sh;
      n.vb   = vb + va_sh;
      n.vacc = d.vacc - ATAN;
    end
    // rotation: drive the residual angle towards zero
    if (!d.rm[ACC_W-1]) begin
      n.ra = ra - rb_sh;
      n.rb = rb + ra_sh;
      n.rm = d.rm - ATAN;
    end else begin
      n.ra = ra + rb_sh;
      n.rb = rb - ra_sh;
      n.rm = d.rm + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q <= n;
    end
  end

endmodule

[rtl/core/fvr_finish.sv]
module fvr_finish
  import fvr_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  fvr_lane_t          d,
  output logic               done,
  output logic signed [15:0] horiz_force,
  output logic signed [15:0] vert_force,
  output logic [14:0]        force_angle,
  output logic               clipped
);

  localparam int PROD_W = VEC_W + 31;
  localparam int Q_W    = PROD_W - GAIN_SHIFT;
  localparam int SH     = FINE_BITS - ANGLE_FRAC_BITS;

  localparam logic signed [PROD_W-1:0] GAIN_S     = PROD_W'(GAIN_Q30);
  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((64'd1 << GAIN_SHIFT) - 64'd1);
  localparam logic signed [Q_W-1:0]    SAT_HI     = Q_W'(32767);
  localparam logic signed [Q_W-1:0]    SAT_LO     = Q_W'(-32768);
  localparam logic signed [ACC_W-1:0]  RND        = ACC_W'(64'd1 << (SH - 1));
  localparam logic signed [ACC_W-1:0]  ANG_FULL   = ACC_W'(360 << ANGLE_FRAC_BITS);

  // truncate toward zero, then clamp to 16 bits; top bit flags the clamp
  function automatic logic [16:0] trunc_sat(input logic signed [PROD_W-1:0] t);
    logic signed [PROD_W-1:0] adj;
    logic signed [Q_W-1:0]    qv;
    logic [16:0]              res;
    adj = t[PROD_W-1] ? t + TRUNC_BIAS : t;
    qv  = Q_W'(adj >>> GAIN_SHIFT);
    res = {1'b0, qv[15:0]};
    if (qv > SAT_HI) begin
      res = {1'b1, 16'h7fff};
    end else if (qv < SAT_LO) begin
      res = {1'b1, 16'h8000};
    end
    return res;
  endfunction

  // Stage 1: gain compensation and wrapped angle sum
  logic signed [PROD_W-1:0] ph_next;
  logic signed [PROD_W-1:0] pv_next;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  total_next;

  assign ph_next = PROD_W'(d.ra) * GAIN_S;
  assign pv_next = PROD_W'(d.rb) * GAIN_S;
  assign sum     = d.vacc + d.mf;

  always_comb begin
    if (sum[ACC_W-1]) begin
      total_next = sum + TURN_FINE;
    end else if (sum >= TURN_FINE) begin
      total_next = sum - TURN_FINE;
    end else begin
      total_next = sum;
    end
  end

  logic                     f1_valid;
  logic                     f1_zero;
  logic signed [PROD_W-1:0] ph;
  logic signed [PROD_W-1:0] pv;
  logic signed [ACC_W-1:0]  total;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    f1_zero <= d.zero;
    ph      <= ph_next;
    pv      <= pv_next;
    total   <= total_next;
  end

  // Stage 2: round the angle, saturate the components
  logic [16:0]             h_sat;
  logic [16:0]             v_sat;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] ang;

  assign h_sat = trunc_sat(ph);
  assign v_sat = trunc_sat(pv);
  assign rnd   = (total + RND) >>> SH;
  // a value that rounds up to a full turn wraps to zero
  assign ang   = (rnd >= ANG_FULL) ? rnd - ANG_FULL : rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    horiz_force <= f1_zero ? 16'sd0 : $signed(h_sat[15:0]);
    vert_force  <= f1_zero ? 16'sd0 : $signed(v_sat[15:0]);
    force_angle <= f1_zero ? 15'd0 : ang[14:0];
    clipped     <= !f1_zero && (h_sat[16] || v_sat[16]);
  end

endmodule

[sim/force_vector_rotate_core_tb.sv]
module force_vector_rotate_core_tb;
  import fvr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     STEPS      = DEF_CORDIC_STEPS;
  localparam int     ANGLE_FRAC = DEF_ANGLE_FRAC_BITS;
  localparam longint FULL_TURN  = longint'(360) <<< FINE_BITS;
  localparam longint HALF_TURN  = longint'(180) <<< FINE_BITS;
  localparam longint QUARTER    = longint'(90) <<< FINE_BITS;
  localparam int     TAIL_CYCLES = DEF_CORDIC_STEPS + 12;

  localparam longint ATAN_STEP [0:23] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  typedef enum logic [1:0] {OP_SAMPLE, OP_MOUNT, OP_DRAIN} beat_kind_t;

  typedef enum int {GAPS_NONE, GAPS_FULL, GAPS_SPARSE} gap_mode_t;

  typedef struct {
    beat_kind_t         kind;
    logic signed [15:0] x;
    logic signed [15:0] z;
    logic signed [15:0] mount;
    int                 gap;
  } stim_beat_t;

  typedef struct packed {
    logic signed [15:0] horiz;
    logic signed [15:0] vert;
    logic [14:0]        angle;
    logic               clip;
  } rotation_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] x_force = '0;
  logic signed [15:0] z_force = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic signed [15:0] cfg_data = '0;
  logic               done;
  logic signed [15:0] horiz_force;
  logic signed [15:0] vert_force;
  logic [14:0]        force_angle;
  logic               clipped;

  stim_beat_t         stim_beats[$];
  rotation_t          pending_rotations[$];
  stim_beat_t         held;
  logic               held_valid = 1'b0;
  int                 wait_left = 0;
  logic               sample_taken = 1'b0;
  logic               mount_taken = 1'b0;
  logic signed [15:0] mount_now = '0;
  int                 bad_results = 0;

  force_vector_rotate_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .x_force    (x_force),
    .z_force    (z_force),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .horiz_force(horiz_force),
    .vert_force (vert_force),
    .force_angle(force_angle),
    .clipped    (clipped)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Gain-correct one axis, truncate toward zero and saturate; top bit flags saturation.
  function automatic logic [16:0] finish_axis(input longint v);
    longint t;
    longint q;
    t = v * longint'(GAIN_Q30);
    q = (t >= 0) ? (t >>> GAIN_SHIFT) : -((-t) >>> GAIN_SHIFT);
    if (q > 32767) return {1'b1, 16'sd32767};
    if (q < -32768) return {1'b1, 16'h8000};
    return {1'b0, q[15:0]};
  endfunction

  function automatic rotation_t rotate_sample(input logic signed [15:0] xf,
                                              input logic signed [15:0] zf,
                                              input logic signed [15:0] mnt);
    longint    x, z, a, b, na, nb, acc, mf, total, ang;
    logic [16:0] h, v;
    rotation_t r;
    x = xf;
    z = zf;
    r = '0;
    if (x == 0 && z == 0) return r;

    // polar angle of (z, x)
    a = z <<< VEC_SHIFT;
    b = x <<< VEC_SHIFT;
    acc = 0;
    if (a < 0) begin
      a = -a;
      b = -b;
      acc = HALF_TURN;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (b > 0) begin
        na = a + (b >>> i);
        nb = b - (a >>> i);
        acc += ATAN_STEP[i];
      end else begin
        na = a - (b >>> i);
        nb = b + (a >>> i);
        acc -= ATAN_STEP[i];
      end
      a = na;
      b = nb;
    end

    mf = (longint'(mnt) <<< (FINE_BITS - ANGLE_FRAC)) % FULL_TURN;
    if (mf < 0) mf += FULL_TURN;
    total = (acc + mf) % FULL_TURN;
    if (total < 0) total += FULL_TURN;
    ang = (total + (longint'(1) <<< (FINE_BITS - ANGLE_FRAC - 1))) >>> (FINE_BITS - ANGLE_FRAC);
    if (ang >= (longint'(360) <<< ANGLE_FRAC)) ang -= longint'(360) <<< ANGLE_FRAC;

    // rotate (z, x) by the mount angle, folded into [-90, 90]
    a = z <<< VEC_SHIFT;
    b = x <<< VEC_SHIFT;
    if (mf > HALF_TURN) mf -= FULL_TURN;
    if (mf > QUARTER) begin
      a = -a;
      b = -b;
      mf -= HALF_TURN;
    end else if (mf < -QUARTER) begin
      a = -a;
      b = -b;
      mf += HALF_TURN;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (mf >= 0) begin
        na = a - (b >>> i);
        nb = b + (a >>> i);
        mf -= ATAN_STEP[i];
      end else begin
        na = a + (b >>> i);
        nb = b - (a >>> i);
        mf += ATAN_STEP[i];
      end
      a = na;
      b = nb;
    end

    h = finish_axis(a);
    v = finish_axis(b);
    r.horiz = h[15:0];
    r.vert  = v[15:0];
    r.angle = ang[14:0];
    r.clip  = h[16] | v[16];
    return r;
  endfunction

  function automatic int draw_gap(input gap_mode_t mode);
    case (mode)
      GAPS_NONE:   return 0;
      GAPS_FULL:   return $urandom_range(0, 12);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
    endcase
  endfunction

  function automatic logic signed [15:0] draw_force();
    logic signed [15:0] pick;
    case ($urandom_range(0, 9))
      6, 7: begin
        case ($urandom_range(0, 4))
          0:       pick = 16'sh8000;
          1:       pick = 16'sd32767;
          2:       pick = -16'sd1;
          3:       pick = 16'sd1;
          default: pick = '0;
        endcase
      end
      8:       pick = 16'($urandom_range(0, 16)) - 16'sd8;
      9:       pick = '0;
      default: pick = 16'($urandom);
    endcase
    return pick;
  endfunction

  function automatic logic signed [15:0] draw_mount();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 46080)) - 16'sd23040;
  endfunction

  task automatic add_sample(input logic signed [15:0] x, input logic signed [15:0] z,
                            input int gap);
    stim_beat_t s;
    s.kind  = OP_SAMPLE;
    s.x     = x;
    s.z     = z;
    s.mount = '0;
    s.gap   = gap;
    stim_beats.push_back(s);
  endtask

  task automatic add_mount(input logic signed [15:0] m, input int gap);
    stim_beat_t s;
    s.kind  = OP_MOUNT;
    s.x     = '0;
    s.z     = '0;
    s.mount = m;
    s.gap   = gap;
    stim_beats.push_back(s);
  endtask

  task automatic add_drain();
    stim_beat_t s;
    s.kind  = OP_DRAIN;
    s.x     = '0;
    s.z     = '0;
    s.mount = '0;
    s.gap   = 0;
    stim_beats.push_back(s);
  endtask

  // Sender: hold a beat until taken, then wait out the next beat's gap.
  always @(negedge clk) begin : drive_beats
    logic want_sample;
    logic want_mount;
    want_sample = start && !sample_taken;
    want_mount  = cfg_valid && !mount_taken;
    if (!rst && !want_sample && !want_mount) begin
      if (!held_valid && stim_beats.size() > 0) begin
        held       = stim_beats.pop_front();
        held_valid = 1'b1;
        wait_left  = held.gap;
      end
      if (held_valid) begin
        if (wait_left > 0) begin
          wait_left--;
        end else begin
          case (held.kind)
            OP_SAMPLE: begin
              want_sample = 1'b1;
              x_force    <= held.x;
              z_force    <= held.z;
              held_valid  = 1'b0;
            end
            OP_MOUNT: begin
              // only write while nothing is in flight
              if (pending_rotations.size() == 0) begin
                want_mount = 1'b1;
                cfg_data  <= held.mount;
                held_valid = 1'b0;
              end
            end
            default: begin
              if (pending_rotations.size() == 0) held_valid = 1'b0;
            end
          endcase
        end
      end
    end
    start     <= want_sample;
    cfg_valid <= want_mount;
  end

  always @(posedge clk) begin : watch_results
    rotation_t want;
    sample_taken <= !rst && start && !busy;
    mount_taken  <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (done) begin
        if (pending_rotations.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: result with none expected: h=%0d v=%0d ang=%0d clip=%0b",
                     $realtime, horiz_force, vert_force, force_angle, clipped);
        end else begin
          want = pending_rotations.pop_front();
          if (horiz_force !== want.horiz || vert_force !== want.vert ||
              force_angle !== want.angle || clipped !== want.clip) begin
            bad_results++;
            if (bad_results <= 10)
              $display("%0t: mismatch exp h=%0d v=%0d ang=%0d clip=%0b, got h=%0d v=%0d ang=%0d clip=%0b",
                       $realtime, want.horiz, want.vert, want.angle, want.clip,
                       horiz_force, vert_force, force_angle, clipped);
          end
        end
      end
      if (start && !busy) pending_rotations.push_back(rotate_sample(x_force, z_force, mount_now));
      if (cfg_valid && cfg_ready) mount_now = cfg_data;
    end
  end

  initial begin : run_stimulus
    gap_mode_t mode;
    int        n_items;

    // reset mount angle: axes, extremes and the zero vector
    add_sample(16'sd0, 16'sd0, draw_gap(GAPS_FULL));
    add_sample(16'sd32767, 16'sd0, draw_gap(GAPS_FULL));
    add_sample(16'sh8000, 16'sd0, 0);
    add_sample(16'sd0, 16'sd32767, 0);
    add_sample(16'sd0, 16'sh8000, draw_gap(GAPS_FULL));
    add_sample(16'sd1, 16'sd0, 0);
    add_sample(-16'sd1, 16'sd0, draw_gap(GAPS_FULL));
    add_sample(16'sd0, 16'sd1, 0);
    add_sample(16'sd0, -16'sd1, 0);
    add_sample(16'sd32767, 16'sd32767, draw_gap(GAPS_FULL));
    add_sample(16'sh8000, 16'sh8000, 0);
    add_sample(16'sh8000, 16'sd32767, 0);
    add_sample(16'sd32767, 16'sh8000, draw_gap(GAPS_FULL));
    // 45 degrees drives the diagonals into saturation
    add_mount(16'sd2880, 0);
    add_sample(16'sd32767, 16'sd32767, 0);
    add_sample(16'sh8000, 16'sh8000, draw_gap(GAPS_FULL));
    add_sample(16'sd0, 16'sd0, 0);
    add_sample(16'sd32767, 16'sd1, 0);
    // mount angles beyond a full turn
    add_mount(16'sh8000, draw_gap(GAPS_FULL));
    add_sample(16'sd12345, -16'sd4321, 0);
    add_sample(16'sd0, 16'sh8000, 0);
    add_mount(16'sd32767, 0);
    add_sample(-16'sd1, 16'sd1, 0);
    add_sample(16'sd32767, 16'sd0, draw_gap(GAPS_FULL));

    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       add_mount(-16'sd23040, draw_gap(GAPS_FULL));
        1:       add_mount(16'sd23040, 0);
        2:       add_mount(16'sd0, draw_gap(GAPS_FULL));
        3:       add_mount(16'sd5760, 0);
        4:       add_mount(-16'sd5760, draw_gap(GAPS_FULL));
        5:       add_mount(16'sd11520, 0);
        6:       add_mount(-16'sd11520, draw_gap(GAPS_FULL));
        7:       add_mount(16'sd32767, 0);
        8:       add_mount(16'sh8000, draw_gap(GAPS_FULL));
        default: add_mount(draw_mount(), draw_gap(GAPS_FULL));
      endcase
      mode    = gap_mode_t'(p % 3);
      n_items = $urandom_range(50, 66);
      for (int k = 0; k < n_items; k++) begin
        // pause mid-phase until the pipeline has emptied
        if (k == n_items / 2 && p % 4 == 1) add_drain();
        add_sample(draw_force(), draw_force(), draw_gap(mode));
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (stim_beats.size() != 0 || held_valid || start || cfg_valid ||
           pending_rotations.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (bad_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
